// File: rtl/trss_pkg.sv
// Shared types, constants and helper functions of the trade row statistics block.
package trss_pkg;

  localparam int TsBits    = 64;
  localparam int ValueBits = 40;
  localparam int CountBits = 25;
  localparam int IndexBits = 5;
  localparam int CfgIdxBits = 2;

  localparam logic [CountBits-1:0] MaxRows = CountBits'(24'd8388608) << 1;

  localparam logic [63:0] ShortGapReset = 64'd100000000;
  localparam logic [63:0] LongGapReset  = 64'd1000000000;
  localparam logic [2:0]  MaskReset     = 3'b111;

  // Configuration register indexes.
  localparam logic [CfgIdxBits-1:0] CfgShortGap = 2'd0;
  localparam logic [CfgIdxBits-1:0] CfgLongGap  = 2'd1;
  localparam logic [CfgIdxBits-1:0] CfgMask     = 2'd2;

  localparam int QueueDepth   = 4;
  localparam int QueuePtrBits = 2;

  localparam logic [63:0] S64Max = {1'b0, {63{1'b1}}};
  localparam logic [63:0] S64Min = {1'b1, {63{1'b0}}};
  localparam logic [ValueBits-1:0] VMax = {1'b0, {(ValueBits-1){1'b1}}};
  localparam logic [ValueBits-1:0] VMin = {1'b1, {(ValueBits-1){1'b0}}};

  // One classified row as it travels from the front to the back.
  typedef struct packed {
    logic                 ts_col;
    logic                 px_col;
    logic                 qty_col;
    logic                 px_zero;
    logic                 qty_zero;
    logic                 last;
    logic [TsBits-1:0]    ts;
    logic [ValueBits-1:0] px;
    logic [ValueBits-1:0] qty;
  } item_t;

  typedef struct packed {
    logic                 start;
    logic [63:0]          dividend;
    logic [CountBits-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
  } div_resp_t;

  function automatic logic [CountBits-1:0] bump(input logic [CountBits-1:0] c);
    logic [CountBits-1:0] r;
    r = (c < MaxRows) ? c + CountBits'(1) : c;
    return r;
  endfunction

  // Signed 64-bit sum plus a sign-extended value, clamped at the 64-bit limits.
  function automatic logic [63:0] sat_add(input logic [63:0] a,
                                          input logic [ValueBits-1:0] b);
    logic [64:0] s;
    logic [63:0] r;
    s = {a[63], a} + {{(65-ValueBits){b[ValueBits-1]}}, b};
    if (s[64] != s[63]) begin
      r = s[64] ? S64Min : S64Max;
    end else begin
      r = s[63:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/trss_front.sv
// Front end: accepts rows and classifies their columns by the present mask.
module trss_front (
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [63:0]                 timestamp_ns_i,
  input  logic [39:0]                 price_i,
  input  logic [39:0]                 quantity_i,
  input  logic                        last_row_i,
  input  logic [2:0]                  mask_i,
  input  logic                        q_full_i,
  output logic                        q_push_o,
  output trss_pkg::item_t             q_item_o
);

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_item_o          = '0;
    q_item_o.ts_col   = mask_i[0];
    q_item_o.px_col   = mask_i[1];
    q_item_o.qty_col  = mask_i[2];
    q_item_o.px_zero  = (price_i[trss_pkg::ValueBits-1:0] == '0);
    q_item_o.qty_zero = (quantity_i[trss_pkg::ValueBits-1:0] == '0);
    q_item_o.last     = last_row_i;
    q_item_o.ts       = timestamp_ns_i;
    q_item_o.px       = price_i[trss_pkg::ValueBits-1:0];
    q_item_o.qty      = quantity_i[trss_pkg::ValueBits-1:0];
  end

endmodule

// File: rtl/trss_queue.sv
// Short queue of classified rows between the front and the back.
module trss_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  trss_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output trss_pkg::item_t item_o,
  output logic            empty_o
);

  trss_pkg::item_t mem_q [trss_pkg::QueueDepth];
  logic [trss_pkg::QueuePtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [trss_pkg::QueuePtrBits:0]   count_q;

  assign full_o  = (count_q == (trss_pkg::QueuePtrBits+1)'(trss_pkg::QueueDepth));
  assign empty_o = (count_q == '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// File: rtl/trss_div.sv
// Restoring divider: 64-bit dividend by 25-bit divisor, one quotient bit a cycle.
module trss_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  trss_pkg::div_req_t  req_i,
  output trss_pkg::div_resp_t resp_o
);

  logic                            busy_q, done_q;
  logic [5:0]                      step_q;
  logic [63:0]                     quo_q;
  logic [trss_pkg::CountBits-1:0]  rem_q, div_q;
  logic [trss_pkg::CountBits:0]    rem_shift, rem_sub;
  logic                            take;

  assign rem_shift = {rem_q, quo_q[63]};
  assign rem_sub   = rem_shift - {1'b0, div_q};
  assign take      = (rem_shift >= {1'b0, div_q});

  assign resp_o.done     = done_q;
  assign resp_o.quotient = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      div_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[62:0], take};
      rem_q <= take ? rem_sub[trss_pkg::CountBits-1:0]
                    : rem_shift[trss_pkg::CountBits-1:0];
    end
  end

endmodule

// File: rtl/trss_back.sv
// Back end: two-stage statistics update, mean division and result sequencing.
module trss_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [63:0]                 short_thr_i,
  input  logic [63:0]                 long_thr_i,
  input  logic                        q_empty_i,
  input  trss_pkg::item_t             q_item_i,
  output logic                        q_pop_o,
  output trss_pkg::div_req_t          div_req_o,
  input  trss_pkg::div_resp_t         div_resp_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [4:0]                  stat_index_o,
  output logic [63:0]                 stat_value_o,
  output logic                        last_stat_o
);

  localparam int CB = trss_pkg::CountBits;
  localparam int VB = trss_pkg::ValueBits;

  localparam logic [2:0] StRun      = 3'd0;
  localparam logic [2:0] StDrain    = 3'd1;
  localparam logic [2:0] StDivStart = 3'd2;
  localparam logic [2:0] StDivWait  = 3'd3;
  localparam logic [2:0] StEmit     = 3'd4;

  localparam logic [1:0] DivGap = 2'd0;
  localparam logic [1:0] DivPx  = 2'd1;
  localparam logic [1:0] DivQty = 2'd2;

  localparam int CntShort  = 0;
  localparam int CntLong   = 1;
  localparam int CntDecr   = 2;
  localparam int CntPxZero = 3;
  localparam int CntQtZero = 4;
  localparam int CntTsNull = 5;
  localparam int CntPxNull = 6;
  localparam int CntQtNull = 7;

  localparam logic [4:0] StatRows    = 5'd0;
  localparam logic [4:0] StatTsMin   = 5'd1;
  localparam logic [4:0] StatTsMax   = 5'd2;
  localparam logic [4:0] StatMaxGap  = 5'd3;
  localparam logic [4:0] StatShort   = 5'd4;
  localparam logic [4:0] StatLong    = 5'd5;
  localparam logic [4:0] StatDecr    = 5'd6;
  localparam logic [4:0] StatGapMean = 5'd7;
  localparam logic [4:0] StatPxMin   = 5'd8;
  localparam logic [4:0] StatPxMax   = 5'd9;
  localparam logic [4:0] StatPxMean  = 5'd10;
  localparam logic [4:0] StatPxZero  = 5'd11;
  localparam logic [4:0] StatQtMin   = 5'd12;
  localparam logic [4:0] StatQtMax   = 5'd13;
  localparam logic [4:0] StatQtMean  = 5'd14;
  localparam logic [4:0] StatQtZero  = 5'd15;
  localparam logic [4:0] StatTsNull  = 5'd16;
  localparam logic [4:0] StatPxNull  = 5'd17;
  localparam logic [4:0] StatQtNull  = 5'd18;

  logic [2:0]    state_q, state_d;
  logic [CB-1:0] rows_q, rows_d;
  logic [CB-1:0] cnt_q [8];
  logic [CB-1:0] cnt_d [8];
  logic [63:0]   ts_min_q, ts_min_d, ts_max_q, ts_max_d, prev_q, prev_d;
  logic          ts_seen_q, ts_seen_d;
  logic [63:0]   gap_q, gap_d;
  logic          gap_vld_q, gap_vld_d;
  logic [63:0]   max_gap_q, max_gap_d, gap_sum_q, gap_sum_d;
  logic [VB-1:0] px_min_q, px_min_d, px_max_q, px_max_d;
  logic [VB-1:0] qt_min_q, qt_min_d, qt_max_q, qt_max_d;
  logic [63:0]   px_sum_q, px_sum_d, qt_sum_q, qt_sum_d;
  logic [1:0]    div_sel_q, div_sel_d;
  logic          mean_neg_q, mean_neg_d;
  logic [63:0]   gap_mean_q, gap_mean_d, px_mean_q, px_mean_d, qt_mean_q, qt_mean_d;
  logic [4:0]    pos_q, pos_d;
  logic          out_valid_q, out_valid_d;
  logic [4:0]    out_idx_q, out_idx_d;
  logic [63:0]   out_val_q, out_val_d;
  logic          out_last_q, out_last_d;

  logic [CB-1:0] ts_n, px_n, qt_n, gap_n;
  logic [64:0]   gap_sum_ext;
  logic [63:0]   stat_val, quo_signed, sum_sel;
  logic          load, clear;

  assign ts_n  = rows_q - cnt_q[CntTsNull];
  assign px_n  = rows_q - cnt_q[CntPxNull];
  assign qt_n  = rows_q - cnt_q[CntQtNull];
  assign gap_n = (ts_seen_q && ts_n != '0) ? ts_n - CB'(1) : '0;

  assign q_pop_o = (state_q == StRun) && !q_empty_i;
  assign load    = (state_q == StEmit) && (!out_valid_q || !out_stall_i);
  assign clear   = load && (pos_q == StatQtNull);

  assign gap_sum_ext = {1'b0, gap_sum_q} + {1'b0, gap_q};

  // Divider operands: magnitudes for the signed sums.
  always_comb begin
    div_req_o       = '0;
    div_req_o.start = (state_q == StDivStart);
    sum_sel         = px_sum_q;
    unique case (div_sel_q)
      DivGap: begin
        div_req_o.dividend = gap_sum_q;
        div_req_o.divisor  = gap_n;
      end
      DivPx: begin
        div_req_o.dividend = px_sum_q[63] ? -px_sum_q : px_sum_q;
        div_req_o.divisor  = px_n;
      end
      default: begin
        sum_sel            = qt_sum_q;
        div_req_o.dividend = qt_sum_q[63] ? -qt_sum_q : qt_sum_q;
        div_req_o.divisor  = qt_n;
      end
    endcase
  end

  assign quo_signed = mean_neg_q ? -div_resp_i.quotient : div_resp_i.quotient;

  always_comb begin
    unique case (pos_q)
      StatRows:    stat_val = 64'(rows_q);
      StatTsMin:   stat_val = (ts_n != '0) ? ts_min_q : '0;
      StatTsMax:   stat_val = (ts_n != '0) ? ts_max_q : '0;
      StatMaxGap:  stat_val = max_gap_q[63] ? trss_pkg::S64Max : max_gap_q;
      StatShort:   stat_val = 64'(cnt_q[CntShort]);
      StatLong:    stat_val = 64'(cnt_q[CntLong]);
      StatDecr:    stat_val = 64'(cnt_q[CntDecr]);
      StatGapMean: stat_val = (gap_n == '0) ? '0 :
                              (gap_mean_q[63] ? trss_pkg::S64Max : gap_mean_q);
      StatPxMin:   stat_val = (px_n != '0) ? {{(64-VB){px_min_q[VB-1]}}, px_min_q} : '0;
      StatPxMax:   stat_val = (px_n != '0) ? {{(64-VB){px_max_q[VB-1]}}, px_max_q} : '0;
      StatPxMean:  stat_val = (px_n != '0) ? px_mean_q : '0;
      StatPxZero:  stat_val = 64'(cnt_q[CntPxZero]);
      StatQtMin:   stat_val = (qt_n != '0) ? {{(64-VB){qt_min_q[VB-1]}}, qt_min_q} : '0;
      StatQtMax:   stat_val = (qt_n != '0) ? {{(64-VB){qt_max_q[VB-1]}}, qt_max_q} : '0;
      StatQtMean:  stat_val = (qt_n != '0) ? qt_mean_q : '0;
      StatQtZero:  stat_val = 64'(cnt_q[CntQtZero]);
      StatTsNull:  stat_val = 64'(cnt_q[CntTsNull]);
      StatPxNull:  stat_val = 64'(cnt_q[CntPxNull]);
      default:     stat_val = 64'(cnt_q[CntQtNull]);
    endcase
  end

  always_comb begin
    state_d     = state_q;
    rows_d      = rows_q;
    cnt_d       = cnt_q;
    ts_min_d    = ts_min_q;
    ts_max_d    = ts_max_q;
    prev_d      = prev_q;
    ts_seen_d   = ts_seen_q;
    gap_d       = gap_q;
    gap_vld_d   = 1'b0;
    max_gap_d   = max_gap_q;
    gap_sum_d   = gap_sum_q;
    px_min_d    = px_min_q;
    px_max_d    = px_max_q;
    qt_min_d    = qt_min_q;
    qt_max_d    = qt_max_q;
    px_sum_d    = px_sum_q;
    qt_sum_d    = qt_sum_q;
    div_sel_d   = div_sel_q;
    mean_neg_d  = mean_neg_q;
    gap_mean_d  = gap_mean_q;
    px_mean_d   = px_mean_q;
    qt_mean_d   = qt_mean_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_idx_d   = out_idx_q;
    out_val_d   = out_val_q;
    out_last_d  = out_last_q;

    // First stage: row count, extremes, sums, zero and null counts, decreases and the raw gap.
    if (q_pop_o) begin
      rows_d = trss_pkg::bump(rows_q);
      if (q_item_i.ts_col) begin
        if ($signed(q_item_i.ts) < $signed(ts_min_q)) ts_min_d = q_item_i.ts;
        if ($signed(q_item_i.ts) > $signed(ts_max_q)) ts_max_d = q_item_i.ts;
        if (ts_seen_q) begin
          gap_vld_d = 1'b1;
          if ($signed(q_item_i.ts) >= $signed(prev_q)) begin
            gap_d = q_item_i.ts - prev_q;
          end else begin
            gap_d          = '0;
            cnt_d[CntDecr] = trss_pkg::bump(cnt_q[CntDecr]);
          end
        end
        prev_d    = q_item_i.ts;
        ts_seen_d = 1'b1;
      end else begin
        cnt_d[CntTsNull] = trss_pkg::bump(cnt_q[CntTsNull]);
      end
      if (q_item_i.px_col) begin
        if ($signed(q_item_i.px) < $signed(px_min_q)) px_min_d = q_item_i.px;
        if ($signed(q_item_i.px) > $signed(px_max_q)) px_max_d = q_item_i.px;
        px_sum_d = trss_pkg::sat_add(px_sum_q, q_item_i.px);
        if (q_item_i.px_zero) cnt_d[CntPxZero] = trss_pkg::bump(cnt_q[CntPxZero]);
      end else begin
        cnt_d[CntPxNull] = trss_pkg::bump(cnt_q[CntPxNull]);
      end
      if (q_item_i.qty_col) begin
        if ($signed(q_item_i.qty) < $signed(qt_min_q)) qt_min_d = q_item_i.qty;
        if ($signed(q_item_i.qty) > $signed(qt_max_q)) qt_max_d = q_item_i.qty;
        qt_sum_d = trss_pkg::sat_add(qt_sum_q, q_item_i.qty);
        if (q_item_i.qty_zero) cnt_d[CntQtZero] = trss_pkg::bump(cnt_q[CntQtZero]);
      end else begin
        cnt_d[CntQtNull] = trss_pkg::bump(cnt_q[CntQtNull]);
      end
      if (q_item_i.last) state_d = StDrain;
    end

    // Second stage: the maximum gap, threshold counts and the gap sum.
    if (gap_vld_q) begin
      if (gap_q > max_gap_q) max_gap_d = gap_q;
      if (gap_q >= short_thr_i) cnt_d[CntShort] = trss_pkg::bump(cnt_q[CntShort]);
      if (gap_q >= long_thr_i)  cnt_d[CntLong]  = trss_pkg::bump(cnt_q[CntLong]);
      gap_sum_d = gap_sum_ext[64] ? '1 : gap_sum_ext[63:0];
    end

    unique case (state_q)
      StDrain: begin
        div_sel_d = DivGap;
        state_d   = StDivStart;
      end
      StDivStart: begin
        mean_neg_d = (div_sel_q != DivGap) && sum_sel[63];
        state_d    = StDivWait;
      end
      StDivWait: begin
        if (div_resp_i.done) begin
          unique case (div_sel_q)
            DivGap:  gap_mean_d = div_resp_i.quotient;
            DivPx:   px_mean_d  = quo_signed;
            default: qt_mean_d  = quo_signed;
          endcase
          if (div_sel_q == DivQty) begin
            pos_d   = StatRows;
            state_d = StEmit;
          end else begin
            div_sel_d = div_sel_q + 1'b1;
            state_d   = StDivStart;
          end
        end
      end
      StEmit: begin
        if (load) begin
          out_valid_d = 1'b1;
          out_idx_d   = pos_q;
          out_val_d   = stat_val;
          out_last_d  = (pos_q == StatQtNull);
          pos_d       = pos_q + 1'b1;
        end
      end
      default: ;
    endcase

    // Last result loaded: drop the statistics and take rows again.
    if (clear) begin
      state_d     = StRun;
      rows_d      = '0;
      for (int i = 0; i < 8; i++) cnt_d[i] = '0;
      ts_min_d    = trss_pkg::S64Max;
      ts_max_d    = trss_pkg::S64Min;
      prev_d      = '0;
      ts_seen_d   = 1'b0;
      max_gap_d   = '0;
      gap_sum_d   = '0;
      px_min_d    = trss_pkg::VMax;
      px_max_d    = trss_pkg::VMin;
      qt_min_d    = trss_pkg::VMax;
      qt_max_d    = trss_pkg::VMin;
      px_sum_d    = '0;
      qt_sum_d    = '0;
      pos_d       = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StRun;
      rows_q      <= '0;
      for (int i = 0; i < 8; i++) cnt_q[i] <= '0;
      ts_min_q    <= trss_pkg::S64Max;
      ts_max_q    <= trss_pkg::S64Min;
      prev_q      <= '0;
      ts_seen_q   <= 1'b0;
      gap_vld_q   <= 1'b0;
      max_gap_q   <= '0;
      gap_sum_q   <= '0;
      px_min_q    <= trss_pkg::VMax;
      px_max_q    <= trss_pkg::VMin;
      qt_min_q    <= trss_pkg::VMax;
      qt_max_q    <= trss_pkg::VMin;
      px_sum_q    <= '0;
      qt_sum_q    <= '0;
      div_sel_q   <= DivGap;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rows_q      <= rows_d;
      cnt_q       <= cnt_d;
      ts_min_q    <= ts_min_d;
      ts_max_q    <= ts_max_d;
      prev_q      <= prev_d;
      ts_seen_q   <= ts_seen_d;
      gap_vld_q   <= gap_vld_d;
      max_gap_q   <= max_gap_d;
      gap_sum_q   <= gap_sum_d;
      px_min_q    <= px_min_d;
      px_max_q    <= px_max_d;
      qt_min_q    <= qt_min_d;
      qt_max_q    <= qt_max_d;
      px_sum_q    <= px_sum_d;
      qt_sum_q    <= qt_sum_d;
      div_sel_q   <= div_sel_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gap_q      <= gap_d;
    mean_neg_q <= mean_neg_d;
    gap_mean_q <= gap_mean_d;
    px_mean_q  <= px_mean_d;
    qt_mean_q  <= qt_mean_d;
    out_idx_q  <= out_idx_d;
    out_val_q  <= out_val_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign stat_index_o = out_idx_q;
  assign stat_value_o = out_val_q;
  assign last_stat_o  = out_last_q;

endmodule

// File: rtl/trade_row_stream_statistics.sv
// Top level of the trade row statistics block: configuration registers and wiring.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-------------------------------------
//   in      | input     | in_valid_i / in_stall_o   | timestamp_ns_i, price_i, quantity_i,
//           |           |                           | last_row_i
//   out     | output    | out_valid_o / out_stall_i | stat_index_o, stat_value_o, last_stat_o
//   cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// Rows enter at one per cycle into a 4-entry queue; the back end, while running, retires one
// row per cycle through its two update stages. After the last row it drains, computes three
// means through one shared bit-serial divider, then emits 19 results, one per cycle unless
// out_stall_i is high. Rows arriving meanwhile wait in the queue; in_stall_o rises when full.
// rst_ni clears all statistics at once and sets the registers to their defaults.
module trade_row_stream_statistics (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] timestamp_ns_i,
  input  logic [39:0] price_i,
  input  logic [39:0] quantity_i,
  input  logic        last_row_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  stat_index_o,
  output logic [63:0] stat_value_o,
  output logic        last_stat_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  logic [63:0] short_thr_q, long_thr_q;
  logic [2:0]  mask_q;

  trss_pkg::item_t     push_item, pop_item;
  logic                q_push, q_pop, q_full, q_empty;
  trss_pkg::div_req_t  div_req;
  trss_pkg::div_resp_t div_resp;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_thr_q <= trss_pkg::ShortGapReset;
      long_thr_q  <= trss_pkg::LongGapReset;
      mask_q      <= trss_pkg::MaskReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        trss_pkg::CfgShortGap: short_thr_q <= cfg_data_i;
        trss_pkg::CfgLongGap:  long_thr_q  <= cfg_data_i;
        trss_pkg::CfgMask:     mask_q      <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  trss_front u_front (
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .timestamp_ns_i (timestamp_ns_i),
    .price_i        (price_i),
    .quantity_i     (quantity_i),
    .last_row_i     (last_row_i),
    .mask_i         (mask_q),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_item_o       (push_item)
  );

  trss_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .item_o  (pop_item),
    .empty_o (q_empty)
  );

  trss_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .resp_o (div_resp)
  );

  trss_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .short_thr_i  (short_thr_q),
    .long_thr_i   (long_thr_q),
    .q_empty_i    (q_empty),
    .q_item_i     (pop_item),
    .q_pop_o      (q_pop),
    .div_req_o    (div_req),
    .div_resp_i   (div_resp),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .stat_index_o (stat_index_o),
    .stat_value_o (stat_value_o),
    .last_stat_o  (last_stat_o)
  );

endmodule
